// ===== design/eps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eps_pkg
// Shared types and constants of the procedural eye pixel shader: register
// map, mood codes, colors and the fixed eye geometry.
// ----------------------------------------------------------------------------
package eps_pkg;

    // Configuration port
    localparam int ADDR_W = 5;

    localparam logic [2:0] REG_LEFT_GAZE_DX   = 3'd0;
    localparam logic [2:0] REG_LEFT_GAZE_DY   = 3'd1;
    localparam logic [2:0] REG_RIGHT_GAZE_DX  = 3'd2;
    localparam logic [2:0] REG_RIGHT_GAZE_DY  = 3'd3;
    localparam logic [2:0] REG_MOOD_MODE      = 3'd4;
    localparam logic [2:0] REG_LEFT_BLINK     = 3'd5;
    localparam logic [2:0] REG_RIGHT_BLINK    = 3'd6;
    localparam logic [2:0] REG_IRIS_RGB       = 3'd7;

    // Mood codes
    localparam logic [2:0] MOOD_NORMAL = 3'd0;
    localparam logic [2:0] MOOD_ANGRY  = 3'd1;
    localparam logic [2:0] MOOD_HAPPY  = 3'd2;
    localparam logic [2:0] MOOD_SLEEPY = 3'd3;
    localparam logic [2:0] MOOD_CLOSED = 3'd4;

    // Colors, RGB565
    localparam logic [15:0] COL_BACK   = 16'hFFFF;
    localparam logic [15:0] COL_SCLERA = 16'hF79E;
    localparam logic [15:0] COL_BLACK  = 16'h0000;
    localparam logic [15:0] IRIS_RESET = 16'h001F;

    // Geometry
    localparam int CENTER        = 80;
    localparam int R_SCLERA      = 70;
    localparam int R_IRIS        = 35;
    localparam int R_PUPIL       = 15;
    localparam int LID_ANGRY     = 30;
    localparam int LID_HAPPY     = 40;
    localparam int LID_SLEEPY_UP = 50;
    localparam int LID_SLEEPY_LO = 20;
    localparam int SLOPE_GAIN    = 20;
    localparam int BROW_GAIN     = 25;
    localparam int BROW_TOP      = 10;
    localparam int BROW_DEPTH    = 7;

    // Disk arithmetic on 8-bit coordinates
    localparam int DIFF_W = 10;
    localparam int SQ_W   = 16;

    typedef struct packed {
        logic signed [5:0] left_dx;
        logic signed [5:0] left_dy;
        logic signed [5:0] right_dx;
        logic signed [5:0] right_dy;
        logic [2:0]        mood;
        logic [6:0]        left_blink;
        logic [6:0]        right_blink;
        logic [15:0]       iris_rgb;
    } eps_cfg_t;

endpackage

// ===== design/eps_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eps_cfg_regs
// APB-style register file: gaze offsets, mood, blink rows and iris color.
// ----------------------------------------------------------------------------
module eps_cfg_regs (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [eps_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output eps_pkg::eps_cfg_t         cfg
);
    import eps_pkg::*;

    eps_cfg_t   cfg_reg;
    eps_cfg_t   cfg_next;
    logic [2:0] reg_idx;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_LEFT_GAZE_DX:  cfg_next.left_dx     = pwdata[5:0];
                REG_LEFT_GAZE_DY:  cfg_next.left_dy     = pwdata[5:0];
                REG_RIGHT_GAZE_DX: cfg_next.right_dx    = pwdata[5:0];
                REG_RIGHT_GAZE_DY: cfg_next.right_dy    = pwdata[5:0];
                REG_MOOD_MODE:     cfg_next.mood        = pwdata[2:0];
                REG_LEFT_BLINK:    cfg_next.left_blink  = pwdata[6:0];
                REG_RIGHT_BLINK:   cfg_next.right_blink = pwdata[6:0];
                REG_IRIS_RGB:      cfg_next.iris_rgb    = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{left_dx: '0, left_dy: '0, right_dx: '0, right_dy: '0,
                         mood: MOOD_NORMAL, left_blink: '0, right_blink: '0,
                         iris_rgb: IRIS_RESET};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_LEFT_GAZE_DX:  prdata = {26'd0, cfg_reg.left_dx};
            REG_LEFT_GAZE_DY:  prdata = {26'd0, cfg_reg.left_dy};
            REG_RIGHT_GAZE_DX: prdata = {26'd0, cfg_reg.right_dx};
            REG_RIGHT_GAZE_DY: prdata = {26'd0, cfg_reg.right_dy};
            REG_MOOD_MODE:     prdata = {29'd0, cfg_reg.mood};
            REG_LEFT_BLINK:    prdata = {25'd0, cfg_reg.left_blink};
            REG_RIGHT_BLINK:   prdata = {25'd0, cfg_reg.right_blink};
            REG_IRIS_RGB:      prdata = {16'd0, cfg_reg.iris_rgb};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

// ===== design/eps_const_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eps_const_div
// Two-stage truncating divide by a constant: reciprocal multiply, then one
// remainder check that adds the missing unit.
// ----------------------------------------------------------------------------
module eps_const_div #(
    parameter int DIVISOR = 160,
    parameter int N_W     = 14,
    parameter int Q_W     = 5
) (
    input  logic           aclk,
    input  logic           en,
    input  logic [N_W-1:0] numer,
    output logic [Q_W-1:0] quot
);
    // numer < 2**SHIFT keeps the estimate within one of the true quotient
    localparam int SHIFT = N_W;
    localparam int M_W   = SHIFT + 1;
    localparam int P_W   = N_W + M_W;
    localparam int B_W   = N_W + Q_W;
    localparam logic [M_W-1:0] RECIP = M_W'((1 << SHIFT) / DIVISOR);

    logic [P_W-1:0] prod;
    logic [Q_W-1:0] est_reg;
    logic [Q_W-1:0] est_next;
    logic [N_W-1:0] numer_reg;
    logic [B_W-1:0] back;
    logic [N_W-1:0] rem;
    logic [Q_W-1:0] quot_reg;
    logic [Q_W-1:0] quot_next;

    assign prod     = {{M_W{1'b0}}, numer} * {{N_W{1'b0}}, RECIP};
    assign est_next = prod[SHIFT +: Q_W];

    assign back      = {{N_W{1'b0}}, est_reg} * B_W'(DIVISOR);
    assign rem       = numer_reg - back[N_W-1:0];
    assign quot_next = est_reg + {{(Q_W-1){1'b0}}, (int'(rem) >= DIVISOR)};

    always_ff @(posedge aclk) begin
        if (en) begin
            est_reg   <= est_next;
            numer_reg <= numer;
            quot_reg  <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule

// ===== design/procedural_eye_pixel_shader.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// procedural_eye_pixel_shader
// Per-pixel color of one eye display: sclera, iris, pupil, mood lids, blink
// lids and angry eyebrow, as an RGB565 value.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one item per pixel (column, row, eye side), valid and
//   ready. Result channel m_*: one RGB565 color per item, in input order.
//   Registers are set through the APB-style port while no item is in flight.
//   Pipeline of six register stages: input, coordinate differences, squares
//   and numerators, disk tests with reciprocal multiply, quotient fix-up,
//   color compose. An accepted item shows on m_valid once it has reached
//   the color compose register, when the receiver does not stall.
//   Throughput is one item per cycle while the receiver does not stall;
//   s_ready stays high while the output register is empty or being drained.
//   When the receiver holds m_ready low with a result waiting, the whole
//   pipeline freezes in place and s_ready drops; nothing is lost or repeated.
//   Reset clears all valid bits and sets the registers to their defaults
//   (iris color pure blue, everything else zero). Pixels outside the display
//   come back as the white background.
// ----------------------------------------------------------------------------
module procedural_eye_pixel_shader #(
    parameter int DISP_WIDTH  = 160,
    parameter int DISP_HEIGHT = 160
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [eps_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_pixel_col,
    input  logic [7:0]                 s_pixel_row,
    input  logic                       s_eye_side,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [15:0]                m_pixel_color
);
    import eps_pkg::*;

    localparam int XW_RAW = $clog2(DISP_WIDTH + 1);
    localparam int XW     = (XW_RAW > 8) ? XW_RAW : 8;
    localparam int N20_W  = $clog2(SLOPE_GAIN * DISP_WIDTH + 1);
    localparam int N25_W  = $clog2(BROW_GAIN * DISP_WIDTH + 1);
    localparam int NP_W   = 2 * XW;
    localparam int SQ_Q_W = $clog2(SLOPE_GAIN + 1);
    localparam int BR_Q_W = $clog2(BROW_GAIN + 1);
    localparam int SM_Q_W = $clog2(DISP_WIDTH / 8 + 1);
    localparam int SW     = $clog2(DISP_HEIGHT + DISP_WIDTH + 256) + 2;

    typedef struct packed {
        logic          oor;
        logic [7:0]    y;
        logic          angry;
        logic          happy;
        logic [SW-1:0] upper;
        logic [SW-1:0] lower;
    } eps_lid_t;

    eps_cfg_t cfg;

    eps_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Valid bits, one per stage
    logic [5:0] vld_reg;
    logic [5:0] vld_next;
    logic       en;

    assign en       = !vld_reg[5] || m_ready;
    assign s_ready  = en;
    assign m_valid  = vld_reg[5];
    assign vld_next = {vld_reg[4:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // Stage 1: input register
    logic [7:0] x1_reg, y1_reg;
    logic       side1_reg, oor1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg    <= s_pixel_col;
            y1_reg    <= s_pixel_row;
            side1_reg <= s_eye_side;
            oor1_reg  <= (s_pixel_col >= DISP_WIDTH) || (s_pixel_row >= DISP_HEIGHT);
        end
    end

    // Stage 2: differences, lid numerators, lid heights
    logic signed [DIFF_W-1:0] sdx2_reg, sdy2_reg, idx2_reg, idy2_reg;
    logic signed [DIFF_W-1:0] sdx2_next, sdy2_next, idx2_next, idy2_next;
    logic [XW-1:0]            nu2_reg, nu2_next, ad2_reg, ad2_next;
    eps_lid_t                 ctl2_reg, ctl2_next;

    logic signed [5:0]        gdx, gdy;
    logic signed [DIFF_W-1:0] xs, ys, icx, icy;
    logic signed [XW+1:0]     dsm;
    logic [6:0]               blink_sel;
    logic [SW-1:0]            blink_h, mood_up, mood_lo;

    always_comb begin
        gdx = side1_reg ? cfg.right_dx : cfg.left_dx;
        gdy = side1_reg ? cfg.right_dy : cfg.left_dy;
        xs  = $signed({2'b00, x1_reg});
        ys  = $signed({2'b00, y1_reg});
        icx = DIFF_W'(CENTER) + DIFF_W'($signed(gdx));
        icy = DIFF_W'(CENTER) + DIFF_W'($signed(gdy));
        sdx2_next = xs - DIFF_W'(CENTER);
        sdy2_next = ys - DIFF_W'(CENTER);
        idx2_next = xs - icx;
        idy2_next = ys - icy;

        nu2_next = side1_reg ? (XW'(DISP_WIDTH) - XW'(x1_reg)) : XW'(x1_reg);
        dsm      = $signed((XW + 2)'(x1_reg) << 1) - $signed((XW + 2)'(DISP_WIDTH));
        ad2_next = dsm[XW+1] ? XW'(-dsm) : XW'(dsm);

        blink_sel = side1_reg ? cfg.right_blink : cfg.left_blink;
        mood_up   = '0;
        mood_lo   = '0;
        blink_h   = SW'(blink_sel);
        ctl2_next.angry = 1'b0;
        ctl2_next.happy = 1'b0;
        case (cfg.mood)
            MOOD_ANGRY: begin
                mood_up = SW'(LID_ANGRY);
                ctl2_next.angry = 1'b1;
            end
            MOOD_HAPPY: begin
                mood_lo = SW'(LID_HAPPY);
                ctl2_next.happy = 1'b1;
            end
            MOOD_SLEEPY: begin
                mood_up = SW'(LID_SLEEPY_UP);
                mood_lo = SW'(LID_SLEEPY_LO);
            end
            MOOD_CLOSED: blink_h = SW'(DISP_HEIGHT / 2);
            default: ;
        endcase
        ctl2_next.upper = (blink_h > mood_up) ? blink_h : mood_up;
        ctl2_next.lower = (blink_h > mood_lo) ? blink_h : mood_lo;
        ctl2_next.oor   = oor1_reg;
        ctl2_next.y     = y1_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sdx2_reg <= sdx2_next;
            sdy2_reg <= sdy2_next;
            idx2_reg <= idx2_next;
            idy2_reg <= idy2_next;
            nu2_reg  <= nu2_next;
            ad2_reg  <= ad2_next;
            ctl2_reg <= ctl2_next;
        end
    end

    // Stage 3: squares and divider numerators
    logic signed [2*DIFF_W-1:0] psx, psy, pix, piy;
    logic [SQ_W-1:0]            ssx3_reg, ssy3_reg, isx3_reg, isy3_reg;
    logic [N20_W-1:0]           n20_3_reg;
    logic [N25_W-1:0]           n25_3_reg;
    logic [NP_W-1:0]            dsq3_reg, dsq3_next;
    eps_lid_t                   ctl3_reg;

    assign psx       = sdx2_reg * sdx2_reg;
    assign psy       = sdy2_reg * sdy2_reg;
    assign pix       = idx2_reg * idx2_reg;
    assign piy       = idy2_reg * idy2_reg;
    assign dsq3_next = {{XW{1'b0}}, ad2_reg} * {{XW{1'b0}}, ad2_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            ssx3_reg  <= psx[SQ_W-1:0];
            ssy3_reg  <= psy[SQ_W-1:0];
            isx3_reg  <= pix[SQ_W-1:0];
            isy3_reg  <= piy[SQ_W-1:0];
            n20_3_reg <= N20_W'(nu2_reg * SLOPE_GAIN);
            n25_3_reg <= N25_W'(nu2_reg * BROW_GAIN);
            dsq3_reg  <= dsq3_next;
            ctl3_reg  <= ctl2_reg;
        end
    end

    // Stages 4 and 5: lid offsets through the constant dividers
    logic [SQ_Q_W-1:0] slope_q;
    logic [BR_Q_W-1:0] brow_q;
    logic [SM_Q_W-1:0] smile_q;

    eps_const_div #(.DIVISOR(DISP_WIDTH), .N_W(N20_W), .Q_W(SQ_Q_W)) u_div_slope (
        .aclk (aclk), .en (en), .numer (n20_3_reg), .quot (slope_q)
    );

    eps_const_div #(.DIVISOR(DISP_WIDTH), .N_W(N25_W), .Q_W(BR_Q_W)) u_div_brow (
        .aclk (aclk), .en (en), .numer (n25_3_reg), .quot (brow_q)
    );

    eps_const_div #(.DIVISOR(8 * DISP_WIDTH), .N_W(NP_W), .Q_W(SM_Q_W)) u_div_smile (
        .aclk (aclk), .en (en), .numer (dsq3_reg), .quot (smile_q)
    );

    // Stage 4: disk tests; stage 5: hold them next to the quotients
    logic [SQ_W:0] sclera_sum, iris_sum;
    logic [2:0]    disk4_reg, disk4_next, disk5_reg;
    eps_lid_t      ctl4_reg, ctl5_reg;

    assign sclera_sum = {1'b0, ssx3_reg} + {1'b0, ssy3_reg};
    assign iris_sum   = {1'b0, isx3_reg} + {1'b0, isy3_reg};
    assign disk4_next = {int'(iris_sum) <= R_PUPIL * R_PUPIL,
                         int'(iris_sum) <= R_IRIS * R_IRIS,
                         int'(sclera_sum) <= R_SCLERA * R_SCLERA};

    always_ff @(posedge aclk) begin
        if (en) begin
            disk4_reg <= disk4_next;
            ctl4_reg  <= ctl3_reg;
            disk5_reg <= disk4_reg;
            ctl5_reg  <= ctl4_reg;
        end
    end

    // Stage 6: paint layers in order
    logic signed [SW-1:0] yy, up_lim, lo_lim, brow_lo, brow_hi;
    logic [15:0]          color_reg, color_next;

    always_comb begin
        yy      = $signed(SW'(ctl5_reg.y));
        up_lim  = $signed(ctl5_reg.upper);
        if (ctl5_reg.angry) begin
            up_lim = up_lim - $signed(SW'(slope_q));
        end
        lo_lim  = $signed(SW'(DISP_HEIGHT)) - $signed(ctl5_reg.lower);
        if (ctl5_reg.happy) begin
            lo_lim = lo_lim + $signed(SW'(smile_q));
        end
        brow_lo = $signed(SW'(BROW_TOP)) + $signed(SW'(brow_q));
        brow_hi = brow_lo + $signed(SW'(BROW_DEPTH));

        color_next = disk5_reg[0] ? COL_SCLERA : COL_BACK;
        if (disk5_reg[1]) begin
            color_next = cfg.iris_rgb;
        end
        if (disk5_reg[2]) begin
            color_next = COL_BLACK;
        end
        if (yy < up_lim) begin
            color_next = COL_BLACK;
        end
        if (yy >= lo_lim) begin
            color_next = COL_BLACK;
        end
        if (ctl5_reg.angry && yy >= brow_lo && yy <= brow_hi) begin
            color_next = COL_BLACK;
        end
        if (ctl5_reg.oor) begin
            color_next = COL_BACK;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            color_reg <= color_next;
        end
    end

    assign m_pixel_color = color_reg;

endmodule

// ===== design/eps_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eps_checker
// Port-level checks of the eye pixel shader: reset, flow control and the
// no-stall latency of the pipeline.
// ----------------------------------------------------------------------------
module eps_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_pixel_color
);

    // Output register empties at reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // Input side follows the output register
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready does not track output drain");

    // Stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_color))
        else $error("stalled result changed or dropped");

    // Without stalls an accepted item reaches the output
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready ##1 m_ready ##1 m_ready ##1 m_ready
        ##1 m_ready |=> m_valid)
        else $error("accepted item did not reach the output");

endmodule

bind procedural_eye_pixel_shader eps_checker u_eps_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_pixel_color (m_pixel_color)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for procedural_eye_pixel_shader. Directed pixels
// exercise the sclera, iris and pupil disks, each mood's lids, the blink rows
// and off-display pixels. Random scans then run under random or corner
// register settings. A local shading function computes each pixel's
// color from a copy of the registers; colors coming back are checked in order.
// ----------------------------------------------------------------------------
module tb;
    import eps_pkg::*;

    localparam int W          = 160;
    localparam int H          = 160;
    localparam int CYCLE_MAX  = 600000;
    localparam int DRAIN_WAIT = 8;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_pixel_col = '0;
    logic [7:0]  s_pixel_row = '0;
    logic        s_eye_side = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b1;
    logic [15:0] m_pixel_color;

    eps_cfg_t    shade_cfg;
    logic [15:0] expected_colors[$];
    logic [15:0] want_color;
    int          errors = 0;
    int          cycles = 0;
    int          stall_left = 0;
    int          stall_n;
    bit          took = 1'b0;
    bit          apb_done = 1'b0;
    bit          gap_en = 1'b1;
    bit          stall_en = 1'b1;

    procedural_eye_pixel_shader #(
        .DISP_WIDTH (W),
        .DISP_HEIGHT(H)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_col  (s_pixel_col),
        .s_pixel_row  (s_pixel_row),
        .s_eye_side   (s_eye_side),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_color(m_pixel_color)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic bit in_disk(int x, int y, int cx, int cy, int r);
        return (x - cx) * (x - cx) + (y - cy) * (y - cy) <= r * r;
    endfunction

    function automatic logic [15:0] shade_pixel(logic [7:0] col, logic [7:0] row,
                                                logic side);
        int          x;
        int          y;
        int          ix;
        int          iy;
        int          upper;
        int          lower;
        int          blink;
        int          lim;
        int          span;
        int          d;
        int          off;
        bit          angry;
        bit          happy;
        logic [15:0] c;
        x = int'(col);
        y = int'(row);
        if (x >= W || y >= H) return COL_BACK;
        c = COL_BACK;
        if (in_disk(x, y, CENTER, CENTER, R_SCLERA)) c = COL_SCLERA;
        ix = CENTER + (side ? int'(shade_cfg.right_dx) : int'(shade_cfg.left_dx));
        iy = CENTER + (side ? int'(shade_cfg.right_dy) : int'(shade_cfg.left_dy));
        if (in_disk(x, y, ix, iy, R_IRIS)) c = shade_cfg.iris_rgb;
        if (in_disk(x, y, ix, iy, R_PUPIL)) c = COL_BLACK;

        upper = 0;
        lower = 0;
        angry = 1'b0;
        happy = 1'b0;
        blink = side ? int'(shade_cfg.right_blink) : int'(shade_cfg.left_blink);
        case (shade_cfg.mood)
            MOOD_ANGRY: begin
                upper = LID_ANGRY;
                angry = 1'b1;
            end
            MOOD_HAPPY: begin
                lower = LID_HAPPY;
                happy = 1'b1;
            end
            MOOD_SLEEPY: begin
                upper = LID_SLEEPY_UP;
                lower = LID_SLEEPY_LO;
            end
            MOOD_CLOSED: blink = H / 2;
            default: ;
        endcase
        if (blink > upper) upper = blink;
        if (blink > lower) lower = blink;

        // slope and brow both run from the nose side outward
        span = side ? (W - x) : x;
        if (upper > 0) begin
            lim = upper;
            if (angry) lim -= span * SLOPE_GAIN / W;
            if (y < lim) c = COL_BLACK;
        end
        if (lower > 0) begin
            lim = H - lower;
            if (happy) begin
                d = 2 * x - W;
                lim += (d * d) / (8 * W);
            end
            if (y >= lim) c = COL_BLACK;
        end
        if (angry) begin
            off = y - BROW_TOP - span * BROW_GAIN / W;
            if (off >= 0 && off <= BROW_DEPTH) c = COL_BLACK;
        end
        return c;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if (!stall_en) begin
            m_ready <= 1'b1;
        end else begin
            stall_n = idle_len();
            m_ready <= (stall_n == 0);
            if (stall_n > 0) stall_left = stall_n - 1;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        took <= s_valid && s_ready;
        apb_done <= psel && penable && pwrite && pready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_colors.size() == 0) begin
                    if (errors < 10) $display("unexpected item: color %h", m_pixel_color);
                    errors++;
                end else begin
                    want_color = expected_colors.pop_front();
                    if (m_pixel_color !== want_color) begin
                        if (errors < 10)
                            $display("pixel color mismatch: expected %h, got %h",
                                     want_color, m_pixel_color);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_colors.push_back(shade_pixel(s_pixel_col, s_pixel_row,
                                                      s_eye_side));
        end
    end

    always @(posedge aclk) begin
        if (cycles >= CYCLE_MAX) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Call at a falling edge; returns at the falling edge after the item
    // was taken, with s_valid still high.
    task automatic send_pixel(input logic [7:0] col, input logic [7:0] row,
                              input logic side);
        int gap;
        gap = gap_en ? idle_len() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_pixel_col <= col;
        s_pixel_row <= row;
        s_eye_side  <= side;
        do @(negedge aclk); while (!took);
    endtask

    // Drop valid and hold until every color has come back.
    task automatic drain_pixels();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (expected_colors.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(negedge aclk); while (!apb_done);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // bus goes idle between transfers
        @(negedge aclk);
        case (idx)
            REG_LEFT_GAZE_DX:  shade_cfg.left_dx     = val[5:0];
            REG_LEFT_GAZE_DY:  shade_cfg.left_dy     = val[5:0];
            REG_RIGHT_GAZE_DX: shade_cfg.right_dx    = val[5:0];
            REG_RIGHT_GAZE_DY: shade_cfg.right_dy    = val[5:0];
            REG_MOOD_MODE:     shade_cfg.mood        = val[2:0];
            REG_LEFT_BLINK:    shade_cfg.left_blink  = val[6:0];
            REG_RIGHT_BLINK:   shade_cfg.right_blink = val[6:0];
            REG_IRIS_RGB:      shade_cfg.iris_rgb    = val[15:0];
            default: ;
        endcase
    endtask

    task automatic test_reset_defaults();
        send_pixel(8'd80, 8'd80, 1'b0);
        send_pixel(8'd80, 8'd50, 1'b1);
        send_pixel(8'd80, 8'd12, 1'b0);
        send_pixel(8'd0, 8'd0, 1'b1);
        send_pixel(8'd160, 8'd10, 1'b0);
        send_pixel(8'd255, 8'd255, 1'b1);
        send_pixel(8'd159, 8'd160, 1'b0);
    endtask

    task automatic test_gaze_extremes();
        drain_pixels();
        reg_write(REG_LEFT_GAZE_DX, 32'(6'(-25)));
        reg_write(REG_LEFT_GAZE_DY, 32'd25);
        reg_write(REG_RIGHT_GAZE_DX, 32'd31);
        reg_write(REG_RIGHT_GAZE_DY, 32'(6'(-32)));
        send_pixel(8'd55, 8'd105, 1'b0);
        send_pixel(8'd55, 8'd140, 1'b0);
        send_pixel(8'd111, 8'd48, 1'b1);
        send_pixel(8'd146, 8'd48, 1'b1);
    endtask

    task automatic test_mood_lids();
        drain_pixels();
        reg_write(REG_MOOD_MODE, 32'(MOOD_ANGRY));
        send_pixel(8'd0, 8'd29, 1'b0);
        send_pixel(8'd0, 8'd30, 1'b0);
        send_pixel(8'd0, 8'd17, 1'b1);
        send_pixel(8'd80, 8'd22, 1'b1);
        drain_pixels();
        reg_write(REG_MOOD_MODE, 32'(MOOD_HAPPY));
        send_pixel(8'd80, 8'd119, 1'b0);
        send_pixel(8'd80, 8'd120, 1'b1);
        send_pixel(8'd0, 8'd159, 1'b0);
        drain_pixels();
        reg_write(REG_MOOD_MODE, 32'(MOOD_SLEEPY));
        send_pixel(8'd80, 8'd49, 1'b0);
        send_pixel(8'd80, 8'd140, 1'b1);
        drain_pixels();
        reg_write(REG_MOOD_MODE, 32'(MOOD_CLOSED));
        send_pixel(8'd80, 8'd79, 1'b0);
        send_pixel(8'd80, 8'd80, 1'b1);
        drain_pixels();
        // unused mood codes fall back to normal
        reg_write(REG_MOOD_MODE, 32'd7);
        send_pixel(8'd80, 8'd20, 1'b0);
    endtask

    task automatic test_blink_rows();
        drain_pixels();
        reg_write(REG_MOOD_MODE, 32'(MOOD_NORMAL));
        reg_write(REG_LEFT_BLINK, 32'd80);
        reg_write(REG_RIGHT_BLINK, 32'd127);
        send_pixel(8'd40, 8'd79, 1'b0);
        send_pixel(8'd40, 8'd80, 1'b0);
        send_pixel(8'd40, 8'd90, 1'b1);
        drain_pixels();
        reg_write(REG_LEFT_BLINK, 32'd0);
        reg_write(REG_RIGHT_BLINK, 32'd0);
    endtask

    task automatic test_iris_color();
        drain_pixels();
        reg_write(REG_IRIS_RGB, 32'h0000FFFF);
        send_pixel(8'd136, 8'd48, 1'b1);
        drain_pixels();
        reg_write(REG_IRIS_RGB, 32'd0);
        send_pixel(8'd136, 8'd48, 1'b1);
    endtask

    // kind 0 random, 1 low corner, 2 high corner
    task automatic load_settings(input int kind);
        int   k;
        int   r;
        logic [31:0] v;
        drain_pixels();
        for (k = 0; k < 4; k++) begin
            if (kind == 1) v = 32'(6'(-32));
            else if (kind == 2) v = 32'd31;
            else if ($urandom_range(0, 9) < 7) v = 32'(6'($urandom_range(0, 50) - 25));
            else v = $urandom_range(0, 63);
            reg_write(REG_LEFT_GAZE_DX + 3'(k), v);
        end
        if (kind == 1) v = 32'(MOOD_NORMAL);
        else if (kind == 2) v = 32'd7;
        else if ($urandom_range(0, 9) < 8) v = $urandom_range(0, 4);
        else v = $urandom_range(5, 7);
        reg_write(REG_MOOD_MODE, v);
        for (k = 0; k < 2; k++) begin
            r = $urandom_range(0, 9);
            if (kind == 1) v = 0;
            else if (kind == 2) v = 127;
            else if (r < 5) v = 0;
            else if (r < 8) v = $urandom_range(0, 80);
            else v = $urandom_range(0, 127);
            reg_write(REG_LEFT_BLINK + 3'(k), v);
        end
        if (kind == 1) v = 0;
        else if (kind == 2) v = 32'h0000FFFF;
        else v = $urandom_range(0, 16'hFFFF);
        reg_write(REG_IRIS_RGB, v);
    endtask

    task automatic test_random_scan(input int phases, input int per_phase);
        int p;
        int n;
        logic [7:0] col;
        logic [7:0] row;
        for (p = 0; p < phases; p++) begin
            load_settings(p == 1 ? 1 : (p == 2 ? 2 : 0));
            gap_en   = (p % 4 != 0);
            stall_en = (p % 4 != 0);
            for (n = 0; n < per_phase; n++) begin
                if (p == 3 && n == per_phase / 2) drain_pixels();
                if ($urandom_range(0, 99) < 85) begin
                    col = 8'($urandom_range(0, W - 1));
                    row = 8'($urandom_range(0, H - 1));
                end else begin
                    col = 8'($urandom_range(0, 255));
                    row = 8'($urandom_range(0, 255));
                end
                send_pixel(col, row, 1'($urandom_range(0, 1)));
            end
        end
        gap_en   = 1'b1;
        stall_en = 1'b1;
    endtask

    initial begin
        shade_cfg = '{left_dx: '0, left_dy: '0, right_dx: '0, right_dy: '0,
                      mood: MOOD_NORMAL, left_blink: '0, right_blink: '0,
                      iris_rgb: IRIS_RESET};
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        test_reset_defaults();
        test_gaze_extremes();
        test_mood_lids();
        test_blink_rows();
        test_iris_color();
        test_random_scan(10, 48);

        drain_pixels();
        repeat (20) @(negedge aclk);
        if (errors == 0 && expected_colors.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
